/* design/bmff_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bmff_pkg
// Shared types and fixed field widths of the bitmap first-fit frame allocator.
// -----------------------------------------------------------------------------
package bmff_pkg;

	// width of the byte length, byte offset and result offset fields
	localparam int unsigned FIELD_W = 13;

	// frame size is a power of two: byte to frame is a right shift
	localparam int unsigned FRAME_SH    = 4;
	localparam int unsigned FRAME_BYTES = 1 << FRAME_SH;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic {
		ST_DONE    = 1'b0,
		ST_NO_ROOM = 1'b1
	} status_t;

endpackage
`default_nettype wire

/* design/bmff_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bmff_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// -----------------------------------------------------------------------------
module bmff_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* design/bmff_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bmff_div
// Byte count to frame index: shift right by the frame size, registered; done
// and the result follow in the cycle after start.
// -----------------------------------------------------------------------------
module bmff_div
	import bmff_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [FIELD_W-1:0] dividend,
	output logic                    done,
	output logic      [FIELD_W-1:0] quotient
);

	logic               done_q;
	logic [FIELD_W-1:0] quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend >> FRAME_SH;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

/* design/bitmap_first_fit_frame_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bitmap_first_fit_frame_allocator
// First-fit allocator of contiguous frame runs over a used-bit bitmap in RAM.
// -----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: opcode; tdata: byte_length, byte_offset
// m_*       out  m_tvalid/m_tready  tuser: status; tdata: alloc_offset
//
// Sequence: each transaction walks a sequencer. The frame count (length over
//   FRAME_BYTES, a shift) comes from the divider; a free then sends its offset
//   through the divider too. An allocate scans one bitmap byte per cycle up to
//   the byte where the run completes; the run's bytes are then swept
//   read-modify-write, one per cycle, and the final load fills the output register.
// Reset: after arst_n releases, a clearing pass writes zeros to all MAP_BYTES
//   bytes of the bitmap, one per cycle; s_tready stays low meanwhile.
// Stalls: the result sits in an output register; a new transaction is taken
//   while it waits, and only the final load waits on m_tready.
// -----------------------------------------------------------------------------
module bitmap_first_fit_frame_allocator
	import bmff_pkg::*;
#(
	parameter int unsigned MAP_BYTES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [12:0] byte_length, [25:13] byte_offset, rest 0
	input  wire logic [0:0]  s_tuser,   // [0] opcode

	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,   // [12:0] alloc_offset, rest 0
	output logic      [0:0]  m_tuser    // [0] status
);

	localparam int unsigned TOTAL_FRAMES = MAP_BYTES * 8;
	// width that holds the frame count itself
	localparam int unsigned FW = $clog2(TOTAL_FRAMES + 1);
	// frame arithmetic width: covers frame indexes and run ends past the map
	localparam int unsigned LW = ((FW > FIELD_W + 1) ? FW : FIELD_W + 1) + 1;
	localparam int unsigned YW = LW - 3;      // byte index width for run ends
	localparam int unsigned AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int unsigned BW = $clog2(MAP_BYTES + 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DLEN,
		S_DOFF,
		S_SCAN,
		S_MARK,
		S_FIN
	} state_t;

	state_t state_q;

	// transaction context
	logic               op_q;
	logic [FIELD_W-1:0] off_q;
	logic [FIELD_W-1:0] qlen_q;     // length / FRAME_BYTES, so need = qlen_q + 1
	logic               fail_q;

	// scan and sweep
	logic [BW-1:0] scan_cnt_q;
	logic [LW-1:0] run_q;
	logic [LW-1:0] start_q;
	logic [LW-1:0] lo_q;
	logic [LW-1:0] hi_q;
	logic [YW-1:0] cur_q;
	logic [YW-1:0] last_q;
	logic          v_s1;            // RAM read data valid this cycle
	logic [AW-1:0] b_s1;            // byte index of that data
	logic [AW-1:0] clr_q;

	// result register
	logic               out_valid_q;
	logic               out_status_q;
	logic [FIELD_W-1:0] out_ofs_q;

	// frame index unit
	logic               div_start;
	logic [FIELD_W-1:0] div_dividend;
	logic               div_done;
	logic [FIELD_W-1:0] div_q;

	// RAM
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	logic s_acc;
	logic out_load;

	assign s_acc    = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_load = (state_q == S_FIN) && (!out_valid_q || m_tready);

	// Frame index unit shared by the length and the free offset
	assign div_start    = s_acc || ((state_q == S_DLEN) && div_done && (op_q == OP_FREE));
	assign div_dividend = s_acc ? s_tdata[FIELD_W-1:0] : off_q;

	bmff_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.done     (div_done),
		.quotient (div_q)
	);

	// First-fit step over one bitmap byte, eight frames in order
	logic [LW-1:0] need_w;
	logic [LW-1:0] scan_run_n;
	logic [LW-1:0] scan_start_n;
	logic          scan_found;

	assign need_w = LW'(qlen_q) + LW'(1);

	always_comb begin
		scan_run_n   = run_q;
		scan_start_n = start_q;
		scan_found   = 1'b0;
		for (int p = 0; p < 8; p++) begin
			if (!scan_found) begin
				if (!ram_rdata[p]) begin
					if (scan_run_n == '0) begin
						scan_start_n = LW'({b_s1, 3'(p)});
					end
					scan_run_n = scan_run_n + LW'(1);
				end else begin
					scan_run_n = '0;
				end
				if (scan_run_n == need_w) begin
					scan_found = 1'b1;
				end
			end
		end
	end

	// Run bounds for the sweep: first frame from the scan or the divider
	logic [LW-1:0] lo_cand;
	logic [LW-1:0] hi_cand;
	logic [YW-1:0] last_cand;

	always_comb begin
		lo_cand   = (state_q == S_SCAN) ? scan_start_n : LW'(div_q);
		hi_cand   = lo_cand + LW'(qlen_q);
		last_cand = hi_cand[LW-1:3];
		// frames past the map end are ignored
		if (last_cand > YW'(MAP_BYTES - 1)) begin
			last_cand = YW'(MAP_BYTES - 1);
		end
	end

	// Bit mask of the run within the byte being swept
	logic [7:0] run_mask;

	always_comb begin
		for (int p = 0; p < 8; p++) begin
			run_mask[p] = (LW'({b_s1, 3'(p)}) >= lo_q) && (LW'({b_s1, 3'(p)}) <= hi_q);
		end
	end

	logic mark_issue;
	logic scan_issue;

	assign mark_issue = (cur_q <= last_q);
	assign scan_issue = (scan_cnt_q < BW'(MAP_BYTES));

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = b_s1;
		ram_wdata = (op_q == OP_ALLOC) ? (ram_rdata | run_mask) : (ram_rdata & ~run_mask);
		ram_raddr = scan_cnt_q[AW-1:0];
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_MARK: begin
				ram_we    = v_s1;
				ram_raddr = cur_q[AW-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	bmff_ram #(
		.WIDTH (8),
		.DEPTH (MAP_BYTES)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result offset: first frame times frame size, low 13 bits
	logic [LW+FIELD_W-1:0] ofs_prod;

	assign ofs_prod = (LW+FIELD_W)'(start_q) * (LW+FIELD_W)'(FRAME_BYTES);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a load in the same cycle as a pop keeps valid high
			out_valid_q <= out_load || (out_valid_q && !m_tready);
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAP_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_acc) begin
						op_q    <= s_tuser[0];
						off_q   <= s_tdata[2*FIELD_W-1:FIELD_W];
						fail_q  <= 1'b0;
						state_q <= S_DLEN;
					end
				end
				S_DLEN: begin
					if (div_done) begin
						qlen_q <= div_q;
						if (op_q == OP_ALLOC) begin
							run_q      <= '0;
							start_q    <= '0;
							scan_cnt_q <= '0;
							v_s1       <= 1'b0;
							state_q    <= S_SCAN;
						end else begin
							state_q <= S_DOFF;
						end
					end
				end
				S_DOFF: begin
					if (div_done) begin
						v_s1   <= 1'b0;
						lo_q   <= lo_cand;
						hi_q   <= hi_cand;
						cur_q  <= lo_cand[LW-1:3];
						last_q <= last_cand;
						if (lo_cand < LW'(TOTAL_FRAMES)) begin
							state_q <= S_MARK;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					b_s1 <= scan_cnt_q[AW-1:0];
					if (scan_issue) begin
						scan_cnt_q <= scan_cnt_q + BW'(1);
					end
					if (v_s1 && scan_found) begin
						lo_q    <= lo_cand;
						hi_q    <= hi_cand;
						cur_q   <= lo_cand[LW-1:3];
						last_q  <= last_cand;
						v_s1    <= 1'b0;
						state_q <= S_MARK;
					end else begin
						v_s1 <= scan_issue;
						if (v_s1 && (b_s1 == AW'(MAP_BYTES - 1))) begin
							fail_q  <= 1'b1;
							state_q <= S_FIN;
						end
					end
					if (v_s1) begin
						run_q   <= scan_run_n;
						start_q <= scan_start_n;
					end
				end
				S_MARK: begin
					v_s1 <= mark_issue;
					b_s1 <= cur_q[AW-1:0];
					if (mark_issue) begin
						cur_q <= cur_q + YW'(1);
					end else if (!v_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						out_status_q <= fail_q;
						out_ofs_q    <= (fail_q || (op_q == OP_FREE)) ? '0
						                                              : ofs_prod[FIELD_W-1:0];
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tuser[0] = out_status_q;
	assign m_tdata    = {3'b000, out_ofs_q};

	// Checks
	a_noroom_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == ST_NO_ROOM) |-> (m_tdata == '0))
		else $error("no-room result carries a nonzero offset");

	a_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> (state_q == S_DLEN))
		else $error("accepted transaction did not start the divider");

	a_div_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DLEN || state_q == S_DOFF))
		else $error("divider finished while the sequencer was not waiting");

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || (state_q == S_MARK && v_s1)))
		else $error("bitmap written outside the clear pass or the run sweep");

	a_sweep_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK) && v_s1 |-> (run_mask != '0))
		else $error("sweep touched a byte outside the run");

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bitmap first-fit frame allocator. A bit-level
// model of the frame map predicts every reply as each request transaction is
// taken. A monitor compares each reply transaction with the oldest prediction.
// Traffic: directed corner cases, random allocate/free traffic, a long output
// stall that backs up the request side, and a stretch with no idling.
// -----------------------------------------------------------------------------
module testbench;
	import bmff_pkg::*;

	// 64 map bytes x 8 bits = 512 frames of 16 bytes
	localparam int FRAMES      = 512;
	localparam int FRAME_BYTES = 16;
	localparam int GAP_MAX     = 18;
	// long output stall, longer than a dozen back-to-back transactions
	localparam int HOLD_CYCLES = 2000;
	// quiet time at the end, longer than the slowest transaction
	localparam int SETTLE      = 300;
	localparam logic [FIELD_W-1:0] LEN_MAX = {FIELD_W{1'b1}};

	typedef struct packed {
		status_t            status;
		logic [FIELD_W-1:0] offset;
	} reply_t;

	// one live allocation, kept so that most frees hit real runs
	typedef struct {
		logic [FIELD_W-1:0] offset;
		logic [FIELD_W-1:0] len;
	} run_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [12:0] byte_length, [25:13] byte_offset, rest 0
	logic [0:0]  s_tuser;   // [0] opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [12:0] alloc_offset, rest 0
	logic [0:0]  m_tuser;   // [0] status

	// predictor state: one used-bit per frame
	logic [FRAMES-1:0] frame_map;
	reply_t            reply_queue[$];
	run_t              live_runs[$];
	int                err_count;
	int                send_gap_max;
	int                recv_gap_max;
	bit                hold_req;

	bitmap_first_fit_frame_allocator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Expected reply of one request; updates the frame map as the block would.
	function automatic reply_t first_fit_outcome(input op_t op,
			input logic [FIELD_W-1:0] len, input logic [FIELD_W-1:0] off);
		reply_t rep;
		int     need;
		int     run;
		int     start;
		int     first;
		bit     found;
		need       = int'(len) / FRAME_BYTES + 1;
		rep.status = ST_DONE;
		rep.offset = '0;
		if (op == OP_ALLOC) begin
			run   = 0;
			start = 0;
			found = 1'b0;
			// lowest run of free frames that is long enough
			for (int f = 0; f < FRAMES && !found; f++) begin
				if (!frame_map[f]) begin
					if (run == 0)
						start = f;
					run++;
				end else begin
					run = 0;
				end
				if (run == need)
					found = 1'b1;
			end
			if (!found) begin
				// no room: map untouched
				rep.status = ST_NO_ROOM;
			end else begin
				for (int f = 0; f < need; f++)
					frame_map[start + f] = 1'b1;
				rep.offset = FIELD_W'(start * FRAME_BYTES);
			end
		end else begin
			// offset rounds down to a frame; frames past the end are dropped
			first = int'(off) / FRAME_BYTES;
			for (int f = 0; f < need; f++)
				if (first + f < FRAMES)
					frame_map[first + f] = 1'b0;
		end
		return rep;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		err_count++;
	endtask

	// Offers one request after a random gap and holds it until taken; the
	// prediction is made at the accepting edge, so it follows the block's order.
	task automatic send_item(input op_t op, input logic [FIELD_W-1:0] len,
			input logic [FIELD_W-1:0] off, output reply_t rep);
		int gap;
		gap = $urandom_range(send_gap_max, 0);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, off, len};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		rep = first_fit_outcome(op, len, off);
		reply_queue.push_back(rep);
	endtask

	// Drops the request valid and waits for every outstanding reply.
	// Always waits on the clock before it checks, so valid is never lowered
	// and raised in the same step.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (reply_queue.size() != 0);
	endtask

	// Mostly small sizes so the map fragments; sometimes the full range.
	function automatic logic [FIELD_W-1:0] pick_len();
		case ($urandom_range(9, 0))
			0, 1, 2, 3, 4, 5: return FIELD_W'($urandom_range(127, 0));
			6, 7:             return FIELD_W'($urandom_range(1023, 128));
			8:                return FIELD_W'($urandom_range(8191, 1024));
			default:          return FIELD_W'($urandom);
		endcase
	endfunction

	// Corner cases: size edges, first-fit reuse of a hole, full map, no room,
	// unaligned free, free past the end, free of free frames, ignored offset.
	task automatic test_directed();
		reply_t r;
		send_gap_max = GAP_MAX;
		recv_gap_max = GAP_MAX;
		send_item(OP_ALLOC, 13'd0,    13'd0,    r);  // 1 frame at 0
		send_item(OP_ALLOC, 13'd15,   13'd0,    r);  // 1 frame at 16
		send_item(OP_ALLOC, 13'd16,   13'd0,    r);  // 2 frames at 32
		send_item(OP_FREE,  13'd0,    13'd23,   r);  // unaligned, frees frame 1
		send_item(OP_ALLOC, 13'd0,    13'd4095, r);  // reuses the hole at 16
		send_item(OP_ALLOC, LEN_MAX,  13'd0,    r);  // whole map wanted: no room
		send_item(OP_FREE,  LEN_MAX,  13'd0,    r);  // clears everything
		send_item(OP_ALLOC, LEN_MAX,  LEN_MAX,  r);  // whole map, offset ignored
		send_item(OP_ALLOC, 13'd0,    13'd0,    r);  // map full: no room
		send_item(OP_FREE,  LEN_MAX,  LEN_MAX,  r);  // last frame; rest past end
		send_item(OP_ALLOC, 13'd0,    13'd0,    r);  // lands on the last frame
		send_item(OP_FREE,  LEN_MAX,  13'd0,    r);
		send_item(OP_FREE,  13'd100,  13'd0,    r);  // already free
		send_item(OP_ALLOC, 13'd5000, 13'd1234, r);
		send_item(OP_ALLOC, 13'd5000, 13'd0,    r);  // too few frames left
		send_item(OP_ALLOC, 13'd3168, 13'd0,    r);  // exactly the remaining run
		send_item(OP_FREE,  13'd8000, 13'd8000, r);  // mostly past the end
		send_item(OP_FREE,  LEN_MAX,  13'd0,    r);
		wait_drained();
		live_runs.delete();
	endtask

	// Random traffic: allocations, frees of live runs (with random low offset
	// bits), stray frees and the occasional full wipe. Every 4th stretch of
	// 80 transactions runs with no idling on either side.
	task automatic test_random_traffic(input int n_items);
		reply_t             r;
		int                 pick;
		int                 idx;
		logic [FIELD_W-1:0] len;
		logic [FIELD_W-1:0] off;
		for (int i = 0; i < n_items; i++) begin
			send_gap_max = ((i / 80) % 4 == 3) ? 0 : GAP_MAX;
			recv_gap_max = send_gap_max;
			pick = $urandom_range(99, 0);
			if (pick < 50) begin
				len = pick_len();
				off = FIELD_W'($urandom);
				send_item(OP_ALLOC, len, off, r);
				if (r.status == ST_DONE)
					live_runs.push_back('{r.offset, len});
			end else if (pick < 85 && live_runs.size() > 0) begin
				idx = $urandom_range(live_runs.size() - 1, 0);
				off = live_runs[idx].offset | FIELD_W'($urandom_range(15, 0));
				len = live_runs[idx].len;
				live_runs.delete(idx);
				send_item(OP_FREE, len, off, r);
			end else if (pick < 97) begin
				len = ($urandom_range(3, 0) == 0) ? FIELD_W'($urandom) :
					FIELD_W'($urandom_range(63, 0));
				send_item(OP_FREE, len, FIELD_W'($urandom), r);
			end else begin
				send_item(OP_FREE, LEN_MAX, 13'd0, r);
				live_runs.delete();
			end
		end
		wait_drained();
	endtask

	// Output side stalls for a long stretch while requests keep coming
	// back to back: the block's output register fills and s_tready drops.
	task automatic test_output_stall();
		reply_t r;
		send_gap_max = 0;
		recv_gap_max = GAP_MAX;
		hold_req     = 1'b1;
		repeat (12)
			send_item(OP_ALLOC, FIELD_W'($urandom_range(63, 0)), FIELD_W'($urandom), r);
		send_item(OP_FREE, LEN_MAX, 13'd0, r);
		wait_drained();
		live_runs.delete();
	endtask

	// Both sides at full rate, mixed allocate and free.
	task automatic test_no_idle(input int n_items);
		reply_t r;
		send_gap_max = 0;
		recv_gap_max = 0;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(2, 0) != 0)
				send_item(OP_ALLOC, pick_len(), FIELD_W'($urandom), r);
			else
				send_item(OP_FREE, pick_len(), FIELD_W'($urandom), r);
		end
		wait_drained();
	endtask

	// Reply side: a random wait before each transaction, or the long hold
	// when a test asks for it; the hold is counted here.
	initial begin : reply_sink
		int w;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				w        = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				w = $urandom_range(recv_gap_max, 0);
			end
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// Reply monitor: every reply transaction against the oldest prediction.
	always @(posedge clk) begin
		reply_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (reply_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected reply status=%0b data=%h",
					m_tuser[0], m_tdata));
			end else begin
				exp_r = reply_queue.pop_front();
				if (m_tuser[0] !== exp_r.status)
					report_mismatch($sformatf("status %0b, expected %0b",
						m_tuser[0], exp_r.status));
				if (m_tdata[FIELD_W-1:0] !== exp_r.offset)
					report_mismatch($sformatf("alloc_offset %0d, expected %0d",
						m_tdata[FIELD_W-1:0], exp_r.offset));
				if (m_tdata[15:FIELD_W] !== '0)
					report_mismatch($sformatf("tdata padding %b not zero",
						m_tdata[15:FIELD_W]));
			end
		end
	end

	// Timeout: well above the time that ~700 transactions with both gaps and
	// the long hold can take.
	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n       <= 1'b0;
		s_tvalid     <= 1'b0;
		s_tdata      <= '0;
		s_tuser      <= OP_ALLOC;
		err_count    = 0;
		send_gap_max = GAP_MAX;
		recv_gap_max = GAP_MAX;
		hold_req     = 1'b0;
		frame_map    = '0;
		repeat (6) @(posedge clk);
		// map clearing pass follows; s_tready stays low until it is done
		arst_n <= 1'b1;

		test_directed();
		test_random_traffic(560);
		test_output_stall();
		test_no_idle(100);

		// any stray reply during the quiet time is flagged by the monitor
		repeat (SETTLE) @(posedge clk);
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
